### hdl/assert_macros.svh
// Assertion macros shared by the RTL. Each macro checks one property on the
// rising clock edge and is disabled while the synchronous reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/fbas_pkg.sv
`timescale 1ns / 1ps

package fbas_pkg;

  // Operation codes carried in the func field.
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_AND  = 4'd2,
    OP_OR   = 4'd3,
    OP_NOTA = 4'd4,
    OP_XOR  = 4'd5,
    OP_SHL  = 4'd6,
    OP_SHR  = 4'd7,
    OP_ROL  = 4'd8,
    OP_ROR  = 4'd9,
    OP_INC  = 4'd10,
    OP_DEC  = 4'd11,
    OP_NOR  = 4'd12,
    OP_NAND = 4'd13,
    OP_CONST = 4'd14,
    OP_PASSA = 4'd15
  } alu_op_t;

  // Fixed values used by the constant operation and the borrow rules.
  localparam logic [3:0] CONST_LOW    = 4'b1010;
  localparam logic [3:0] CONST_HIGH   = 4'b0010;
  localparam logic [3:0] BORROW_ADD   = 4'b1111;

  // One input item.
  typedef struct packed {
    logic [3:0] func;
    logic [3:0] operand_a;
    logic [3:0] operand_b;
    logic       carry_in;
    logic       shift_in_high;
    logic       upper_slice;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [3:0] result;
    logic       carry_out;
    logic       shift_out_low;
    logic       zero;
  } out_item_t;

endpackage

### hdl/fbas_chan_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one item of type item_t per handshake.
interface fbas_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/fbas_pipe_reg.sv
`timescale 1ns / 1ps

// One pipeline register stage with valid/ready flow control. The stage
// takes a new item whenever it is empty or its item leaves in the same cycle.
module fbas_pipe_reg #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  item_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output item_t dn_data
);

  logic  valid_r;
  logic  valid_nxt;
  item_t data_r;

  // The stage can take an item when empty or draining this cycle.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload is loaded only on an accepted item.
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### hdl/fbas_alu.sv
`timescale 1ns / 1ps

// Combinational ALU function for one 4-bit slice.
module fbas_alu (
  input  fbas_pkg::in_item_t  op_in,
  output fbas_pkg::out_item_t op_out
);

  logic [3:0] a;
  logic [3:0] b;
  logic [3:0] nb;
  logic       ci;
  logic       up;
  logic [3:0] shr_val;
  logic [5:0] sum;
  logic       arith;
  logic [3:0] res;
  logic       co;
  logic       so;

  assign a       = op_in.operand_a;
  assign b       = op_in.operand_b;
  assign nb      = ~op_in.operand_b;
  assign ci      = op_in.carry_in;
  assign up      = op_in.upper_slice;
  assign shr_val = {op_in.shift_in_high, a[3:1]};

  // Select the operation. Arithmetic and left shifts form a 6-bit sum whose
  // low nibble is the result and whose bit 4 is the carry.
  always_comb begin
    sum   = 6'd0;
    arith = 1'b0;
    res   = 4'd0;
    co    = 1'b0;
    so    = 1'b0;
    case (fbas_pkg::alu_op_t'(op_in.func))
      fbas_pkg::OP_ADD: begin
        sum   = {2'b00, a} + {2'b00, b} + {5'd0, up & ci};
        arith = 1'b1;
      end
      fbas_pkg::OP_SUB: begin
        // The upper slice borrows by adding fifteen when no carry arrives.
        sum   = {2'b00, a} + {2'b00, nb} + 6'd1
              + ((up && !ci) ? {2'b00, fbas_pkg::BORROW_ADD} : 6'd0);
        arith = 1'b1;
      end
      fbas_pkg::OP_AND:  res = a & b;
      fbas_pkg::OP_OR:   res = a | b;
      fbas_pkg::OP_NOTA: res = ~a;
      fbas_pkg::OP_XOR:  res = a ^ b;
      fbas_pkg::OP_SHL: begin
        sum   = {1'b0, a, 1'b0} + {5'd0, up & ci};
        arith = 1'b1;
      end
      fbas_pkg::OP_SHR: begin
        res = shr_val;
        so  = up & a[0];
      end
      fbas_pkg::OP_ROL: begin
        sum   = {1'b0, a, 1'b0} + {5'd0, ci};
        arith = 1'b1;
      end
      fbas_pkg::OP_ROR: begin
        res = shr_val;
        so  = a[0];
      end
      fbas_pkg::OP_INC: begin
        sum   = {2'b00, a} + {5'd0, up ? ci : 1'b1};
        arith = 1'b1;
      end
      fbas_pkg::OP_DEC: begin
        sum   = {2'b00, a} + ((up && ci) ? 6'd0 : {2'b00, fbas_pkg::BORROW_ADD});
        arith = 1'b1;
      end
      fbas_pkg::OP_NOR:  res = ~(a | b);
      fbas_pkg::OP_NAND: res = ~(a & b);
      fbas_pkg::OP_CONST: begin
        if (up) begin
          res = ci ? 4'd0 : fbas_pkg::CONST_HIGH;
          co  = 1'b1;
        end else begin
          res = fbas_pkg::CONST_LOW;
        end
      end
      fbas_pkg::OP_PASSA: res = a;
      default:            res = a;
    endcase
    if (arith) begin
      res = sum[3:0];
      co  = sum[4];
    end
  end

  assign op_out.result        = res;
  assign op_out.carry_out     = co;
  assign op_out.shift_out_low = so;
  assign op_out.zero          = (res == 4'd0);

endmodule

### hdl/four_bit_alu_slice.sv
`timescale 1ns / 1ps

// Cascadable 4-bit ALU slice with sixteen operations. An item enters an input
// register, passes through the ALU logic and lands in a result register, so a
// result is held in that register until it is taken, and one item can be taken
// every cycle. While a finished result waits to be taken, the input stage can
// still take one more item; throughput drops only when the result side holds
// off ready. There is no state beyond the two stages.
`include "assert_macros.svh"

module four_bit_alu_slice (
  input logic clk,
  input logic rst_n,
  fbas_chan_if.sink   in_chan,
  fbas_chan_if.source out_chan
);

  logic                s1_valid;
  logic                s1_ready;
  fbas_pkg::in_item_t  s1_data;
  fbas_pkg::out_item_t alu_out;
  fbas_pkg::in_item_t  in_data;
  fbas_pkg::out_item_t out_data;

  assign in_data = in_chan.data;

  // Input register stage.
  fbas_pipe_reg #(
    .item_t (fbas_pkg::in_item_t)
  ) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // ALU function between the two register stages.
  fbas_alu u_alu (
    .op_in  (s1_data),
    .op_out (alu_out)
  );

  // Result register stage.
  fbas_pipe_reg #(
    .item_t (fbas_pkg::out_item_t)
  ) u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (alu_out),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (out_data)
  );

  assign out_chan.data = out_data;

  // An accepted item always occupies the input stage on the next cycle.
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_chan.valid && in_chan.ready, s1_valid)
  // A stalled item in the input stage stays and keeps its payload.
  `ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid && !s1_ready, s1_valid && $stable(s1_data))
  // The zero flag of a delivered result matches its result nibble.
  `ASSERT_IMPL(a_zero_flag, clk, rst_n, out_chan.valid, out_data.zero == (out_data.result == 4'd0))
  // A waiting result is never dropped or replaced.
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_chan.valid && !out_chan.ready, out_chan.valid && $stable(out_data))

endmodule
